FILE: src/spq_pkg.sv
`default_nettype none

package spq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [0:0] {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic                    shift_in;
      logic                    shift_out;
      logic signed [KEY_W-1:0] key;
   } cell_ctrl_type;

   typedef struct packed {
      status_type              status;
      logic signed [KEY_W-1:0] removed_value;
      logic signed [KEY_W-1:0] front_value;
      logic [CNT_W-1:0]        entry_count;
      logic                    is_empty;
      logic                    is_full;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/sorted_priority_queue.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mode, value
// rsp_      out        rsp_valid/rsp_stall  status, removed_value, front_value,
//                                           entry_count, is_empty, is_full
//
// One item per cycle while req_stall is low: every cell compares against the
// broadcast key and shifts in the same cycle, so an insert or remove finishes
// at its accept edge, when its result enters a two-entry output buffer that
// shows it after earlier results; req_stall is high only while both are held.
// Reset clears the count and the buffer; cell contents are left as they are.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_mode,
   input  wire logic signed [KEY_W-1:0] req_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic signed [KEY_W-1:0]      rsp_removed_value,
   output logic signed [KEY_W-1:0]      rsp_front_value,
   output logic [CNT_W-1:0]             rsp_entry_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full
);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    req_accept;
   logic                    is_insert;
   logic                    q_full;
   logic                    q_empty;
   logic                    do_ins;
   logic                    do_rem;
   logic                    buf_full;
   cell_ctrl_type           ctrl;
   rsp_type                 result;
   rsp_type                 rsp_item;

   logic signed [KEY_W-1:0] cell_val  [CAPACITY];
   logic signed [KEY_W-1:0] cell_next [CAPACITY];
   logic                    cell_gt   [CAPACITY];
   logic [CAPACITY-1:0]     occupied;

   assign req_stall  = buf_full;
   assign req_accept = req_valid & ~req_stall;
   assign is_insert  = (mode_type'(req_mode) == MODE_INSERT);
   assign q_full     = (count_ff == CNT_W'(CAPACITY));
   assign q_empty    = (count_ff == '0);
   assign do_ins     = req_accept & is_insert & ~q_full;
   assign do_rem     = req_accept & ~is_insert & ~q_empty;

   assign ctrl.shift_in  = do_ins;
   assign ctrl.shift_out = do_rem;
   assign ctrl.key       = req_value;

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_val;
      logic                    left_gt;
      logic signed [KEY_W-1:0] right_val;

      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_val = req_value;
         assign left_gt  = 1'b0;
      end else begin : g_mid
         assign left_val = cell_val[i-1];
         assign left_gt  = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_val = cell_val[i];
      end else begin : g_body
         assign right_val = cell_val[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied[i]),
         .prev_val  (left_val),
         .prev_gt   (left_gt),
         .next_val  (right_val),
         .cell_val  (cell_val[i]),
         .cell_next (cell_next[i]),
         .cell_gt   (cell_gt[i])
      );
   end

   always_comb begin
      result.status = ST_DONE;
      if (req_accept && is_insert && q_full) begin
         result.status = ST_FULL;
      end else if (req_accept && !is_insert && q_empty) begin
         result.status = ST_EMPTY;
      end
      result.removed_value = do_rem ? cell_val[0] : '0;
      result.front_value   = (count_in != '0) ? cell_next[0] : '0;
      result.entry_count   = count_in;
      result.is_empty      = (count_in == '0);
      result.is_full       = (count_in == CNT_W'(CAPACITY));
   end

   spq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (result),
      .buf_full  (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_status        = rsp_item.status;
   assign rsp_removed_value = rsp_item.removed_value;
   assign rsp_front_value   = rsp_item.front_value;
   assign rsp_entry_count   = rsp_item.entry_count;
   assign rsp_is_empty      = rsp_item.is_empty;
   assign rsp_is_full       = rsp_item.is_full;

endmodule

`default_nettype wire

FILE: src/spq_cell.sv
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic                    clock,
   input  wire cell_ctrl_type           ctrl,
   input  wire logic                    occupied,
   input  wire logic signed [KEY_W-1:0] prev_val,
   input  wire logic                    prev_gt,
   input  wire logic signed [KEY_W-1:0] next_val,
   output logic signed [KEY_W-1:0]      cell_val,
   output logic signed [KEY_W-1:0]      cell_next,
   output logic                         cell_gt
);

   logic signed [KEY_W-1:0] val_ff;
   logic signed [KEY_W-1:0] val_in;

   assign cell_gt  = occupied & (val_ff > ctrl.key);
   assign cell_val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.shift_in) begin
         // take the left neighbor when it moves up, else drop the key in at the boundary
         if (prev_gt) begin
            val_in = prev_val;
         end else if (cell_gt || !occupied) begin
            val_in = ctrl.key;
         end
      end else if (ctrl.shift_out) begin
         val_in = next_val;
      end
   end

   assign cell_next = val_in;

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

`default_nettype wire

FILE: src/spq_rsp_buf.sv
`default_nettype none

module spq_rsp_buf
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_item,
   output logic         buf_full,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   rsp_type     mem_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic        pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign buf_full  = (cnt_ff == 2'd2);
   assign pop       = rsp_valid & ~rsp_stall;
   assign rsp_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: src/spq_checker.sv
`default_nettype none

module spq_checker
   import spq_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    req_mode,
   input wire logic signed [KEY_W-1:0] req_value,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic [1:0]              rsp_status,
   input wire logic signed [KEY_W-1:0] rsp_removed_value,
   input wire logic signed [KEY_W-1:0] rsp_front_value,
   input wire logic [CNT_W-1:0]        rsp_entry_count,
   input wire logic                    rsp_is_empty,
   input wire logic                    rsp_is_full
);

   // no result may be left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)) &&
                    (rsp_is_full == (rsp_entry_count == CNT_W'(CAPACITY))))
      else $error("empty/full flags disagree with count");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_front_value == '0))
      else $error("front value not zero on empty queue");

   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_is_empty && rsp_removed_value == '0))
      else $error("rejected remove on a non-empty queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_front_value) && $stable(rsp_entry_count)))
      else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

FILE: verif/sorted_priority_queue_tb.sv
module sorted_priority_queue_tb;
   import spq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_mode;
   logic signed [KEY_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [1:0]              rsp_status;
   logic signed [KEY_W-1:0] rsp_removed_value;
   logic signed [KEY_W-1:0] rsp_front_value;
   logic [CNT_W-1:0]        rsp_entry_count;
   logic                    rsp_is_empty;
   logic                    rsp_is_full;

   // keys currently held, ascending; equal keys in arrival order
   logic signed [KEY_W-1:0] held_keys[$];
   rsp_type                 predicted_rsps[$];
   int                      mismatch_count = 0;
   bit                      idle_on = 1'b1;
   int                      stall_left = 0;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type predict_step(input mode_type mode,
                                            input logic signed [KEY_W-1:0] key);
      rsp_type result;
      int      pos;
      result = '0;
      result.status = ST_DONE;
      if (mode == MODE_INSERT) begin
         if (held_keys.size() >= CAPACITY) begin
            result.status = ST_FULL;
         end else begin
            pos = held_keys.size();
            while (pos > 0 && held_keys[pos-1] > key)
               pos--;
            held_keys.insert(pos, key);
         end
      end else begin
         if (held_keys.size() == 0) begin
            result.status = ST_EMPTY;
         end else begin
            result.removed_value = held_keys.pop_front();
         end
      end
      result.front_value = (held_keys.size() > 0) ? held_keys[0] : '0;
      result.entry_count = CNT_W'(held_keys.size());
      result.is_empty    = (held_keys.size() == 0);
      result.is_full     = (held_keys.size() >= CAPACITY);
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [KEY_W-1:0] got,
                              input logic [KEY_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsps.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = predicted_rsps.pop_front();
            check_field("status", KEY_W'(rsp_status), KEY_W'(want.status));
            check_field("removed_value", rsp_removed_value, want.removed_value);
            check_field("front_value", rsp_front_value, want.front_value);
            check_field("entry_count", KEY_W'(rsp_entry_count),
                        KEY_W'(want.entry_count));
            check_field("is_empty", KEY_W'(rsp_is_empty), KEY_W'(want.is_empty));
            check_field("is_full", KEY_W'(rsp_is_full), KEY_W'(want.is_full));
         end
      end
   end

   // result-side stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // call at a falling edge; returns at a falling edge with the item accepted
   task automatic send_item(input mode_type mode, input logic signed [KEY_W-1:0] key);
      int gap;
      bit accepted;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode  = mode;
      req_value = key;
      accepted  = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         if (!req_stall) begin
            accepted = 1'b1;
            predicted_rsps.push_back(predict_step(mode, key));
         end
         @(negedge clock);
      end
   endtask

   // hold off until every expected item has come back
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (predicted_rsps.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic signed [KEY_W-1:0] random_key();
      case ($urandom_range(0, 9))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2, 3:    return int'($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic mode_type random_mode(input int insert_pct);
      return ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
   endfunction

   task automatic test_directed_edges();
      send_item(MODE_REMOVE, 32'sd0);
      send_item(MODE_INSERT, 32'sd0);
      send_item(MODE_INSERT, KEY_MAX);
      send_item(MODE_INSERT, KEY_MIN);
      send_item(MODE_INSERT, -32'sd1);
      send_item(MODE_INSERT, 32'sd1);
      // equal keys
      send_item(MODE_INSERT, 32'sd5);
      send_item(MODE_INSERT, 32'sd5);
      send_item(MODE_INSERT, 32'sd5);
      send_item(MODE_INSERT, 32'sh8000_0001);
      send_item(MODE_INSERT, 32'sh7FFF_FFFE);
      // drain past empty; the value is ignored on remove
      repeat (11) send_item(MODE_REMOVE, $urandom);
   endtask

   task automatic test_fill_and_overflow();
      repeat (CAPACITY) send_item(MODE_INSERT, random_key());
      repeat (3) send_item(MODE_INSERT, random_key());
      repeat (CAPACITY) send_item(MODE_REMOVE, $urandom);
      repeat (2) send_item(MODE_REMOVE, $urandom);
   endtask

   task automatic test_random_mix();
      int insert_pct;
      repeat (10) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 80;
            1:       insert_pct = 20;
            default: insert_pct = 50;
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (40) send_item(random_mode(insert_pct), random_key());
      end
      idle_on = 1'b1;
   endtask

   task automatic test_calm_tail();
      idle_on = 1'b0;
      repeat (30) send_item(MODE_INSERT, random_key());
      repeat (30) send_item(random_mode(40), random_key());
   endtask

   initial begin
      int waited;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_mode  = MODE_INSERT;
      req_value = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      wait_for_drain();
      test_fill_and_overflow();
      wait_for_drain();
      test_random_mix();
      test_calm_tail();

      req_valid = 1'b0;
      waited = 0;
      while (predicted_rsps.size() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
      if (predicted_rsps.size() != 0)
         report_mismatch($sformatf("%0d expected items never arrived",
                                   predicted_rsps.size()));
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
